### rtl/prt_pkg.sv
// shared types and constants for the packet reassembly tracker
`timescale 1ns / 1ps

package prt_pkg;

   localparam int MAP_DEPTH   = 512;
   localparam int QUEUE_DEPTH = 4;

   localparam int ID_W     = 16;
   localparam int FIELD_W  = 16;
   localparam int MAXP_W   = 10;
   localparam int SLOT_W   = 8;
   localparam int BYTES_W  = 17;
   localparam int OFFSET_W = 17;
   localparam int QSLOT_W  = 2;
   localparam int QFILL_W  = 3;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   localparam logic [MAXP_W-1:0] MAX_PACKETS_RESET = MAXP_W'(267);
   localparam logic [SLOT_W-1:0] SLOT_BYTES_RESET  = SLOT_W'(240);
   localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};

   localparam int IDX_W    = $clog2(MAP_DEPTH);
   localparam int CNT_W    = $clog2(MAP_DEPTH + 1);
   localparam int LIM_W    = (CNT_W > MAXP_W) ? CNT_W : MAXP_W;
   localparam int ROW_BITS = (MAP_DEPTH < 32) ? MAP_DEPTH : 32;
   localparam int ROWS     = (MAP_DEPTH + ROW_BITS - 1) / ROW_BITS;
   localparam int ROW_AW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int BIT_AW   = $clog2(ROW_BITS);

   localparam int Q_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int QSUM_W  = Q_AW + 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PACKETS = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BYTES  = CSR_IDX_W'(1);

   localparam logic CMD_HEADER = 1'b0;
   localparam logic CMD_POP    = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } fsm_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_ACCEPTED      = 3'd0,
      STS_MALFORMED     = 3'd1,
      STS_DUPLICATE     = 3'd2,
      STS_QUEUED        = 3'd3,
      STS_DROPPED       = 3'd4,
      STS_POPPED        = 3'd5,
      STS_QUEUE_EMPTY   = 3'd6
   } status_type;

endpackage

### rtl/prt_ram.sv
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps

module prt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/packet_reassembly_tracker.sv
// packet reassembly tracker top level: header checks, seen map, length queue
`timescale 1ns / 1ps

//  channel  | ports                                   | transfer
//  ---------+-----------------------------------------+-------------------------
//  request  | start, busy, req_*                      | start high, busy low
//  result   | rsp_strobe, rsp_*                       | rsp_strobe high, 1 cycle
//  config   | csr_valid, csr_ready, csr_index, csr_wdata | csr_valid and csr_ready
//
//  a command is taken on the accept edge, which reads the seen-map row and the
//  queue head entry from the rams and enters the exec state; the exec state
//  updates state and registers the result, and busy holds off new requests
//  meanwhile; the result strobe shows back in idle, where start may be taken again.
//  synchronous reset clears control state and the seen-map row valid flags.
//  the receiver cannot stall; results are never held back.

module packet_reassembly_tracker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic                                 req_command,
   input  logic [prt_pkg::ID_W-1:0]             req_message_id,
   input  logic [prt_pkg::FIELD_W-1:0]          req_packet_index,
   input  logic [prt_pkg::FIELD_W-1:0]          req_packet_total,
   input  logic [prt_pkg::FIELD_W-1:0]          req_payload_size,
   output logic                                 rsp_strobe,
   output logic [prt_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                 rsp_abandoned_partial,
   output logic [prt_pkg::OFFSET_W-1:0]         rsp_write_offset,
   output logic [prt_pkg::BYTES_W-1:0]          rsp_message_bytes,
   output logic [prt_pkg::QSLOT_W-1:0]          rsp_queue_slot,
   output logic [prt_pkg::QFILL_W-1:0]          rsp_queue_fill,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [prt_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [prt_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   prt_pkg::fsm_type state_ff, state_in;
   logic accept;
   logic exec_en;

   logic [prt_pkg::MAXP_W-1:0] max_packets_ff;
   logic [prt_pkg::SLOT_W-1:0] slot_bytes_ff;

   // captured request
   logic                          cmd_ff;
   logic [prt_pkg::ID_W-1:0]      id_ff;
   logic [prt_pkg::FIELD_W-1:0]   idx_ff;
   logic [prt_pkg::FIELD_W-1:0]   total_ff;
   logic [prt_pkg::FIELD_W-1:0]   size_ff;

   // assembly state
   logic                          assembling_ff, assembling_in;
   logic [prt_pkg::ID_W-1:0]      cur_id_ff, cur_id_in;
   logic [prt_pkg::CNT_W-1:0]     expected_ff, expected_in;
   logic [prt_pkg::CNT_W-1:0]     received_ff, received_in;
   logic [prt_pkg::BYTES_W-1:0]   byte_sum_ff, byte_sum_in;
   logic [prt_pkg::ROWS-1:0]      row_valid_ff, row_valid_in;
   logic [prt_pkg::Q_AW-1:0]      head_ff, head_in;
   logic [prt_pkg::QCNT_W-1:0]    count_ff, count_in;

   // result registers
   logic                          rsp_strobe_ff;
   prt_pkg::status_type           status_ff, status_in;
   logic                          abandoned_ff, abandoned_in;
   logic [prt_pkg::OFFSET_W-1:0]  offset_ff, offset_in;
   logic [prt_pkg::BYTES_W-1:0]   bytes_ff, bytes_in;
   logic [prt_pkg::Q_AW-1:0]      slot_ff, slot_in;

   // ram ports
   logic                          seen_wr_en;
   logic [prt_pkg::ROW_AW-1:0]    seen_rd_addr;
   logic [prt_pkg::ROW_BITS-1:0]  seen_wr_data;
   logic [prt_pkg::ROW_BITS-1:0]  seen_rd_data;
   logic                          fifo_wr_en;
   logic [prt_pkg::Q_AW-1:0]      fifo_wr_addr;
   logic [prt_pkg::BYTES_W-1:0]   fifo_rd_data;

   // exec datapath
   logic [prt_pkg::IDX_W-1:0]     idx_w;
   logic [prt_pkg::ROW_AW-1:0]    row;
   logic [prt_pkg::BIT_AW-1:0]    bit_sel;
   logic [prt_pkg::LIM_W-1:0]     limit;
   logic                          malformed;
   logic                          new_msg;
   logic [prt_pkg::ROW_BITS-1:0]  row_base;
   logic [prt_pkg::CNT_W-1:0]     received_base;
   logic [prt_pkg::CNT_W-1:0]     expected_base;
   logic [prt_pkg::BYTES_W-1:0]   sum_base;
   logic [prt_pkg::BYTES_W:0]     sum_wide;
   logic [prt_pkg::BYTES_W-1:0]   sum_next;
   logic [prt_pkg::CNT_W-1:0]     received_next;
   logic [prt_pkg::QSUM_W-1:0]    tail_sum;
   logic [prt_pkg::Q_AW-1:0]      tail;
   logic [prt_pkg::Q_AW-1:0]      head_next;

   assign accept       = start && !busy;
   assign csr_ready    = 1'b1;
   assign seen_rd_addr = prt_pkg::ROW_AW'(req_packet_index[prt_pkg::IDX_W-1:0]
                                           >> prt_pkg::BIT_AW);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         prt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = prt_pkg::ST_EXEC;
            end
         end
         prt_pkg::ST_EXEC: begin
            state_in = prt_pkg::ST_IDLE;
         end
         default: begin
            state_in = prt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy    = 1'b0;
      exec_en = 1'b0;
      unique case (state_ff)
         prt_pkg::ST_IDLE: begin
            busy = 1'b0;
         end
         prt_pkg::ST_EXEC: begin
            busy    = 1'b1;
            exec_en = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   prt_ram #(
      .WIDTH (prt_pkg::ROW_BITS),
      .DEPTH (prt_pkg::ROWS)
   ) u_seen_ram (
      .clock   (clock),
      .wr_en   (seen_wr_en),
      .wr_addr (row),
      .wr_data (seen_wr_data),
      .rd_en   (accept),
      .rd_addr (seen_rd_addr),
      .rd_data (seen_rd_data)
   );

   prt_ram #(
      .WIDTH (prt_pkg::BYTES_W),
      .DEPTH (prt_pkg::QUEUE_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_wr_en),
      .wr_addr (fifo_wr_addr),
      .wr_data (sum_next),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (fifo_rd_data)
   );

   always_comb begin
      idx_w   = idx_ff[prt_pkg::IDX_W-1:0];
      row     = prt_pkg::ROW_AW'(idx_w >> prt_pkg::BIT_AW);
      bit_sel = idx_w[prt_pkg::BIT_AW-1:0];

      if (prt_pkg::LIM_W'(max_packets_ff) < prt_pkg::LIM_W'(prt_pkg::MAP_DEPTH)) begin
         limit = prt_pkg::LIM_W'(max_packets_ff);
      end else begin
         limit = prt_pkg::LIM_W'(prt_pkg::MAP_DEPTH);
      end

      malformed = (total_ff == '0)
               || (17'(total_ff) > 17'(limit))
               || (idx_ff >= total_ff)
               || (size_ff > prt_pkg::FIELD_W'(slot_bytes_ff));

      new_msg = !assembling_ff || (cur_id_ff != id_ff);

      if (new_msg || !row_valid_ff[row]) begin
         row_base = '0;
      end else begin
         row_base = seen_rd_data;
      end
      received_base = new_msg ? '0 : received_ff;
      expected_base = new_msg ? prt_pkg::CNT_W'(total_ff) : expected_ff;
      sum_base      = new_msg ? '0 : byte_sum_ff;

      sum_wide      = (prt_pkg::BYTES_W+1)'(sum_base) + (prt_pkg::BYTES_W+1)'(size_ff);
      sum_next      = sum_wide[prt_pkg::BYTES_W] ? prt_pkg::BYTES_MAX
                                                 : sum_wide[prt_pkg::BYTES_W-1:0];
      received_next = received_base + prt_pkg::CNT_W'(1);
      seen_wr_data  = row_base | (prt_pkg::ROW_BITS'(1) << bit_sel);

      tail_sum = prt_pkg::QSUM_W'(head_ff) + prt_pkg::QSUM_W'(count_ff);
      if (tail_sum >= prt_pkg::QSUM_W'(prt_pkg::QUEUE_DEPTH)) begin
         tail_sum = tail_sum - prt_pkg::QSUM_W'(prt_pkg::QUEUE_DEPTH);
      end
      tail = prt_pkg::Q_AW'(tail_sum);
      if (head_ff == prt_pkg::Q_AW'(prt_pkg::QUEUE_DEPTH - 1)) begin
         head_next = '0;
      end else begin
         head_next = head_ff + prt_pkg::Q_AW'(1);
      end
   end

   always_comb begin
      assembling_in = assembling_ff;
      cur_id_in     = cur_id_ff;
      expected_in   = expected_ff;
      received_in   = received_ff;
      byte_sum_in   = byte_sum_ff;
      row_valid_in  = row_valid_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      seen_wr_en    = 1'b0;
      fifo_wr_en    = 1'b0;
      fifo_wr_addr  = tail;
      status_in     = prt_pkg::STS_ACCEPTED;
      abandoned_in  = 1'b0;
      offset_in     = '0;
      bytes_in      = '0;
      slot_in       = '0;

      if (cmd_ff == prt_pkg::CMD_POP) begin
         if (count_ff == '0) begin
            status_in = prt_pkg::STS_QUEUE_EMPTY;
         end else begin
            status_in = prt_pkg::STS_POPPED;
            slot_in   = head_ff;
            bytes_in  = fifo_rd_data;
            head_in   = head_next;
            count_in  = count_ff - prt_pkg::QCNT_W'(1);
         end
      end else if (malformed) begin
         status_in = prt_pkg::STS_MALFORMED;
      end else begin
         abandoned_in  = assembling_ff && (cur_id_ff != id_ff);
         assembling_in = 1'b1;
         cur_id_in     = id_ff;
         expected_in   = expected_base;
         received_in   = received_base;
         byte_sum_in   = sum_base;
         if (new_msg) begin
            row_valid_in = '0;
         end
         if (row_base[bit_sel]) begin
            status_in = prt_pkg::STS_DUPLICATE;
         end else begin
            seen_wr_en        = 1'b1;
            row_valid_in[row] = 1'b1;
            offset_in   = prt_pkg::OFFSET_W'(idx_w) * prt_pkg::OFFSET_W'(slot_bytes_ff);
            received_in = received_next;
            byte_sum_in = sum_next;
            status_in   = prt_pkg::STS_ACCEPTED;
            if (received_next == expected_base) begin
               bytes_in = sum_next;
               if (count_ff < prt_pkg::QCNT_W'(prt_pkg::QUEUE_DEPTH)) begin
                  fifo_wr_en = 1'b1;
                  slot_in    = tail;
                  count_in   = count_ff + prt_pkg::QCNT_W'(1);
                  status_in  = prt_pkg::STS_QUEUED;
               end else begin
                  status_in  = prt_pkg::STS_DROPPED;
               end
               assembling_in = 1'b0;
               cur_id_in     = '0;
               expected_in   = '0;
               received_in   = '0;
               byte_sum_in   = '0;
            end
         end
      end
      if (!exec_en) begin
         seen_wr_en = 1'b0;
         fifo_wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= prt_pkg::ST_IDLE;
         max_packets_ff <= prt_pkg::MAX_PACKETS_RESET;
         slot_bytes_ff  <= prt_pkg::SLOT_BYTES_RESET;
         assembling_ff  <= 1'b0;
         cur_id_ff      <= '0;
         expected_ff    <= '0;
         received_ff    <= '0;
         byte_sum_ff    <= '0;
         row_valid_ff   <= '0;
         head_ff        <= '0;
         count_ff       <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= exec_en;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               prt_pkg::CSR_MAX_PACKETS: begin
                  max_packets_ff <= csr_wdata[prt_pkg::MAXP_W-1:0];
               end
               prt_pkg::CSR_SLOT_BYTES: begin
                  slot_bytes_ff <= csr_wdata[prt_pkg::SLOT_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (exec_en) begin
            assembling_ff <= assembling_in;
            cur_id_ff     <= cur_id_in;
            expected_ff   <= expected_in;
            received_ff   <= received_in;
            byte_sum_ff   <= byte_sum_in;
            row_valid_ff  <= row_valid_in;
            head_ff       <= head_in;
            count_ff      <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         id_ff    <= req_message_id;
         idx_ff   <= req_packet_index;
         total_ff <= req_packet_total;
         size_ff  <= req_payload_size;
      end
      if (exec_en) begin
         status_ff    <= status_in;
         abandoned_ff <= abandoned_in;
         offset_ff    <= offset_in;
         bytes_ff     <= bytes_in;
         slot_ff      <= slot_in;
      end
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_status            = status_ff;
   assign rsp_abandoned_partial = abandoned_ff;
   assign rsp_write_offset      = offset_ff;
   assign rsp_message_bytes     = bytes_ff;
   assign rsp_queue_slot        = prt_pkg::QSLOT_W'(slot_ff);
   assign rsp_queue_fill        = prt_pkg::QFILL_W'(count_ff);

endmodule

### dv/tb_packet_reassembly_tracker.sv
// self-checking testbench for the packet reassembly tracker
`timescale 1ns / 1ps

module tb_packet_reassembly_tracker;
   import prt_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 10;
   localparam int ITEMS_PER_PHASE = 105;
   localparam int PHASES          = 9;

   typedef struct {
      status_type            status;
      logic                  abandoned;
      logic [OFFSET_W-1:0]   offset;
      logic [BYTES_W-1:0]    bytes;
      logic [QSLOT_W-1:0]    slot;
      logic [QFILL_W-1:0]    fill;
   } outcome_type;

   class reassembly_ledger;
      logic [MAXP_W-1:0]    max_packets = MAX_PACKETS_RESET;
      logic [SLOT_W-1:0]    slot_bytes  = SLOT_BYTES_RESET;
      bit                   assembling;
      logic [ID_W-1:0]      current_id = '0;
      int unsigned          expected_count;
      int unsigned          received_count;
      int unsigned          byte_sum;
      logic [MAP_DEPTH-1:0] seen_map = '0;
      logic [BYTES_W-1:0]   queue_len [QUEUE_DEPTH];
      int unsigned          queue_head;
      int unsigned          queue_count;
      outcome_type          pending [$];
      int                   mismatches;

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_MAX_PACKETS)
            max_packets = data[MAXP_W-1:0];
         else if (idx == CSR_SLOT_BYTES)
            slot_bytes = data[SLOT_W-1:0];
      endfunction

      function int unsigned packet_limit();
         return (max_packets < MAP_DEPTH) ? max_packets : MAP_DEPTH;
      endfunction

      function void log_request(logic cmd, logic [ID_W-1:0] id, logic [FIELD_W-1:0] idx,
                                logic [FIELD_W-1:0] total, logic [FIELD_W-1:0] size);
         outcome_type o;
         int unsigned sum;
         o.status    = STS_ACCEPTED;
         o.abandoned = 1'b0;
         o.offset    = '0;
         o.bytes     = '0;
         o.slot      = '0;
         if (cmd == CMD_POP) begin
            if (queue_count == 0) begin
               o.status = STS_QUEUE_EMPTY;
            end else begin
               o.status   = STS_POPPED;
               o.slot     = queue_head;
               o.bytes    = queue_len[queue_head];
               queue_head = (queue_head + 1) % QUEUE_DEPTH;
               queue_count--;
            end
         end else if (total == 0 || total > packet_limit() || idx >= total ||
                      size > slot_bytes) begin
            o.status = STS_MALFORMED;
         end else begin
            if (assembling && current_id != id) begin
               o.abandoned = 1'b1;
               assembling  = 1'b0;
            end
            if (!assembling) begin
               assembling     = 1'b1;
               current_id     = id;
               expected_count = total;
               received_count = 0;
               byte_sum       = 0;
               seen_map       = '0;
            end
            if (seen_map[idx]) begin
               o.status = STS_DUPLICATE;
            end else begin
               seen_map[idx] = 1'b1;
               o.offset      = idx * slot_bytes;
               received_count++;
               sum      = byte_sum + size;
               byte_sum = (sum > BYTES_MAX) ? BYTES_MAX : sum;
               if (received_count == expected_count) begin
                  o.bytes = byte_sum;
                  if (queue_count < QUEUE_DEPTH) begin
                     o.slot            = (queue_head + queue_count) % QUEUE_DEPTH;
                     queue_len[o.slot] = byte_sum;
                     queue_count++;
                     o.status = STS_QUEUED;
                  end else begin
                     o.status = STS_DROPPED;
                  end
                  assembling = 1'b0;
               end
            end
         end
         o.fill = queue_count;
         pending.push_back(o);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s expected %0d got %0d", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_outcome(logic [STATUS_W-1:0] status, logic abandoned,
                                  logic [OFFSET_W-1:0] offset, logic [BYTES_W-1:0] bytes,
                                  logic [QSLOT_W-1:0] slot, logic [QFILL_W-1:0] fill);
         outcome_type want;
         if (pending.size() == 0) begin
            $error("result transfer with no request outstanding");
            mismatches++;
            return;
         end
         want = pending.pop_front();
         compare_field("status", want.status, status);
         compare_field("abandoned_partial", want.abandoned, abandoned);
         compare_field("write_offset", want.offset, offset);
         compare_field("message_bytes", want.bytes, bytes);
         compare_field("queue_slot", want.slot, slot);
         compare_field("queue_fill", want.fill, fill);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_command;
   logic [ID_W-1:0]       req_message_id;
   logic [FIELD_W-1:0]    req_packet_index;
   logic [FIELD_W-1:0]    req_packet_total;
   logic [FIELD_W-1:0]    req_payload_size;
   logic                  rsp_strobe;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  rsp_abandoned_partial;
   logic [OFFSET_W-1:0]   rsp_write_offset;
   logic [BYTES_W-1:0]    rsp_message_bytes;
   logic [QSLOT_W-1:0]    rsp_queue_slot;
   logic [QFILL_W-1:0]    rsp_queue_fill;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   reassembly_ledger ledger = new();
   int items_sent;
   int quiet_left;
   int idle_cycles = 0;

   packet_reassembly_tracker dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_message_id        (req_message_id),
      .req_packet_index      (req_packet_index),
      .req_packet_total      (req_packet_total),
      .req_payload_size      (req_payload_size),
      .rsp_strobe            (rsp_strobe),
      .rsp_status            (rsp_status),
      .rsp_abandoned_partial (rsp_abandoned_partial),
      .rsp_write_offset      (rsp_write_offset),
      .rsp_message_bytes     (rsp_message_bytes),
      .rsp_queue_slot        (rsp_queue_slot),
      .rsp_queue_fill        (rsp_queue_fill),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         ledger.check_outcome(rsp_status, rsp_abandoned_partial, rsp_write_offset,
                              rsp_message_bytes, rsp_queue_slot, rsp_queue_fill);
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // idle stretches alternate with runs of back-to-back requests
   function automatic int draw_gap();
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 9) == 0) begin
         quiet_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic int draw_size();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return ledger.slot_bytes;
         default: return $urandom_range(0, ledger.slot_bytes);
      endcase
   endfunction

   task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                            input logic [FIELD_W-1:0] idx, input logic [FIELD_W-1:0] total,
                            input logic [FIELD_W-1:0] size);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start            <= 1'b1;
      req_command      <= cmd;
      req_message_id   <= id;
      req_packet_index <= idx;
      req_packet_total <= total;
      req_payload_size <= size;
      do @(posedge clock); while (busy);
      ledger.log_request(cmd, id, idx, total, size);
      items_sent++;
   endtask

   task automatic send_pop();
      send_item(CMD_POP, $urandom, $urandom, $urandom, $urandom);
   endtask

   // headers that break one rule of the message they sit in, or pure noise
   task automatic send_broken(input logic [ID_W-1:0] id, input int total);
      case ($urandom_range(0, 4))
         0: send_item(CMD_HEADER, id, 0, 0, draw_size());
         1: send_item(CMD_HEADER, id, 0, ledger.packet_limit() + 1 + $urandom_range(0, 3),
                      draw_size());
         2: send_item(CMD_HEADER, id, total + $urandom_range(0, 100), total, draw_size());
         3: send_item(CMD_HEADER, id, $urandom_range(0, total - 1), total,
                      ledger.slot_bytes + 1 + $urandom_range(0, 300));
         default: send_item(CMD_HEADER, $urandom, $urandom, $urandom, $urandom);
      endcase
   endtask

   task automatic send_message(input logic [ID_W-1:0] id, input int total, input bit cut_short);
      int order [$];
      int pick;
      int held;
      int stop_at;
      for (int i = 0; i < total; i++)
         order.push_back(i);
      for (int i = total - 1; i > 0; i--) begin
         pick        = $urandom_range(0, i);
         held        = order[i];
         order[i]    = order[pick];
         order[pick] = held;
      end
      stop_at = (cut_short && total > 1) ? $urandom_range(1, total - 1) : total;
      for (int i = 0; i < stop_at; i++) begin
         if ($urandom_range(0, 3) == 0)
            send_pop();
         if ($urandom_range(0, 19) == 0)
            send_broken(id, total);
         send_item(CMD_HEADER, id, order[i], total, draw_size());
         if (i > 0 && $urandom_range(0, 7) == 0)
            send_item(CMD_HEADER, id, order[$urandom_range(0, i)], total, draw_size());
      end
   endtask

   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (ledger.pending.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      ledger.set_register(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int maxp, input int slot);
      logic [CSR_DATA_W-1:0] slot_word;
      settle();
      write_register(CSR_MAX_PACKETS, maxp);
      slot_word                = $urandom;
      slot_word[SLOT_W-1:0]    = slot;
      write_register(CSR_SLOT_BYTES, slot_word);
   endtask

   initial begin
      int phase_max [PHASES];
      int phase_slot [PHASES];
      int goal;
      int cap;
      logic [ID_W-1:0] id;
      logic [ID_W-1:0] last_id;

      reset            = 1'b1;
      start            = 1'b0;
      req_command      = CMD_HEADER;
      req_message_id   = '0;
      req_packet_index = '0;
      req_packet_total = '0;
      req_payload_size = '0;
      csr_valid        = 1'b0;
      csr_index        = CSR_MAX_PACKETS;
      csr_wdata        = '0;
      items_sent       = 0;
      quiet_left       = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset limits: empty pop, each malformed rule, duplicate, abandon, full queue
      send_pop();
      send_item(CMD_HEADER, 16'h0000, 0, 0, 0);
      send_item(CMD_HEADER, 16'h0001, 0, 268, 1);
      send_item(CMD_HEADER, 16'h0002, 267, 267, 1);
      send_item(CMD_HEADER, 16'h0003, 0, 3, 241);
      send_item(CMD_HEADER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(CMD_HEADER, 16'h1234, 266, 267, 240);
      send_item(CMD_HEADER, 16'h1234, 266, 267, 240);
      send_item(CMD_HEADER, 16'hFFFF, 0, 1, 240);
      send_item(CMD_HEADER, 16'h0000, 2, 3, 0);
      send_item(CMD_HEADER, 16'h0000, 0, 3, 240);
      send_item(CMD_HEADER, 16'h0000, 1, 3, 17);
      send_item(CMD_HEADER, 16'h0007, 0, 1, 0);
      send_item(CMD_HEADER, 16'h0008, 0, 1, 5);
      send_item(CMD_HEADER, 16'h0009, 0, 1, 9);
      repeat (5) send_pop();

      // limit above the map depth, widest stride
      configure(1023, 255);
      send_item(CMD_HEADER, 16'hABCD, 511, 512, 255);
      send_item(CMD_HEADER, 16'hABCD, 0, 513, 1);
      send_item(CMD_HEADER, 16'hABCD, 511, 512, 255);

      phase_max  = '{267, 512, 1023, 1, 0, 30, 7, 0, 0};
      phase_slot = '{240, 255, 128, 1, 77, 0, 255, 0, 0};
      phase_max[7]  = $urandom_range(0, 1023);
      phase_slot[7] = $urandom_range(0, 255);
      phase_max[8]  = $urandom_range(1, 64);
      phase_slot[8] = $urandom_range(1, 255);

      last_id = $urandom;
      for (int p = 0; p < PHASES; p++) begin
         configure(phase_max[p], phase_slot[p]);
         goal = items_sent + ITEMS_PER_PHASE;
         while (items_sent < goal) begin
            id = ($urandom_range(0, 7) == 0) ? last_id : $urandom;
            if (ledger.packet_limit() == 0)
               cap = 6;
            else if ($urandom_range(0, 15) == 0)
               cap = (ledger.packet_limit() < 48) ? ledger.packet_limit() : 48;
            else
               cap = (ledger.packet_limit() < 6) ? ledger.packet_limit() : 6;
            send_message(id, $urandom_range(1, cap), $urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) == 0)
               send_broken(id, 1);
            last_id = id;
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

### packet_reassembly_tracker.f
rtl/prt_pkg.sv
rtl/prt_ram.sv
rtl/packet_reassembly_tracker.sv
dv/tb_packet_reassembly_tracker.sv
